@@ design/box_wind_drag_force_assert.svh @@
// Assertion macros for the box wind drag force block.
// Used by the port checker; expects clk and rst in scope.
`ifndef BOX_WIND_DRAG_FORCE_ASSERT_SVH
`define BOX_WIND_DRAG_FORCE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BWDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box_wind_drag_force: port check failed");

// Next-cycle implication, off while reset is high.
`define BWDF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box_wind_drag_force: port check failed");

// Next-cycle implication that also holds across reset.
`define BWDF_ASSERT_ALW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("box_wind_drag_force: port check failed");

`endif

@@ design/bwdf_pkg.sv @@
// Shared types and constants of the box wind drag force block.
// No dependencies.
package bwdf_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD   = 3'd4;

  // Drag coefficient and force widths
  localparam int COEF_W  = 16;
  localparam int FORCE_W = 32;

  // Bits of a configuration word that the packed registers can keep
  localparam int WORD_LIMIT = 64;

  // Pipeline flow control that travels between the stage groups
  typedef struct packed {
    logic advance;
    logic valid;
  } flow_t;

endpackage

@@ design/box_wind_drag_force.sv @@
// Box wind drag force. One body per item: if the body has finite mass and sits
// inside the box (center +/- half extent per axis, bounds inclusive), the item
// returns the force -v*(k1 + k2*|v|) with v = vel - wind, in Q(2*FRACTION_BITS)
// fixed point, each axis truncated toward zero and saturated to 32 bits signed;
// any other body returns applied = 0 and a zero force. The pipeline accepts one
// item every cycle; an item passes three front stages (box test and relative
// velocity, squares, sum), one stage per root bit of the square root, and four
// back stages (k2*s, coefficient add, split multiply, shift and clamp into the
// output register). The whole pipeline holds while a finished result waits on
// out_ready, and in_ready then falls; nothing is dropped or repeated.
// Configuration writes are always ready and take effect at once; write them
// only while the pipeline is empty. Depends on bwdf_pkg, bwdf_front,
// bwdf_sqrt and bwdf_drag.
module box_wind_drag_force #(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input items
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH-1:0]          pos_x,
  input  logic signed [COORD_WIDTH-1:0]          pos_y,
  input  logic signed [COORD_WIDTH-1:0]          pos_z,
  input  logic signed [COORD_WIDTH-1:0]          vel_x,
  input  logic signed [COORD_WIDTH-1:0]          vel_y,
  input  logic signed [COORD_WIDTH-1:0]          vel_z,
  input  logic                                   infinite_mass,
  // result items
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   applied,
  output logic signed [bwdf_pkg::FORCE_W-1:0]    force_x,
  output logic signed [bwdf_pkg::FORCE_W-1:0]    force_y,
  output logic signed [bwdf_pkg::FORCE_W-1:0]    force_z,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bwdf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [3*COORD_WIDTH-1:0]               cfg_data
);
  import bwdf_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int PACK_W = 3 * CW;
  // packed words keep at most a 64-bit register's worth; higher axes read 0
  localparam int KEEP_W = (PACK_W > WORD_LIMIT) ? WORD_LIMIT : PACK_W;
  localparam int SIDE_W = 3 * CW + 4;

  logic [PACK_W-1:0]    wind_velocity;
  logic [PACK_W-1:0]    box_center;
  logic [PACK_W-1:0]    box_half_extent;
  logic [COEF_W-1:0]    linear_coef;
  logic [COEF_W-1:0]    quadratic_coef;

  logic                 advance;
  flow_t                flow_in;
  flow_t                flow_front;
  flow_t                flow_root;
  logic [2*CW-1:0]      sum;
  logic [SIDE_W-1:0]    side_front;
  logic [SIDE_W-1:0]    side_root;
  logic [CW-1:0]        root;
  logic [3*FORCE_W-1:0] force_all;

  // Configuration registers: always ready, unknown indexes drop the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_velocity   <= '0;
      box_center      <= '0;
      box_half_extent <= '0;
      linear_coef     <= '0;
      quadratic_coef  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIND:   wind_velocity   <= PACK_W'(cfg_data[KEEP_W-1:0]);
        REG_CENTER: box_center      <= PACK_W'(cfg_data[KEEP_W-1:0]);
        REG_HALF:   box_half_extent <= PACK_W'(cfg_data[KEEP_W-1:0]);
        REG_LIN:    linear_coef     <= cfg_data[COEF_W-1:0];
        REG_QUAD:   quadratic_coef  <= cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance every stage together unless the output register holds an item
  // that the consumer has not taken; bubbles advance along with the items.
  assign advance         = !out_valid || out_ready;
  assign in_ready        = advance;
  assign flow_in.advance = advance;
  assign flow_in.valid   = in_valid;

  bwdf_front #(
    .CW (CW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .flow_in       (flow_in),
    .pos           ({pos_z, pos_y, pos_x}),
    .vel           ({vel_z, vel_y, vel_x}),
    .infinite_mass (infinite_mass),
    .wind          (wind_velocity),
    .center        (box_center),
    .half          (box_half_extent),
    .flow_out      (flow_front),
    .sum           (sum),
    .side          (side_front)
  );

  // Root of the squared length; the sideband carries applied, signs and |v|.
  bwdf_sqrt #(
    .RW     (CW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .flow_in  (flow_front),
    .n        (sum),
    .side_in  (side_front),
    .flow_out (flow_root),
    .root     (root),
    .side_out (side_root)
  );

  bwdf_drag #(
    .CW (CW),
    .FB (FRACTION_BITS)
  ) u_drag (
    .clk       (clk),
    .rst       (rst),
    .flow_in   (flow_root),
    .root      (root),
    .side_in   (side_root),
    .lin_coef  (linear_coef),
    .quad_coef (quadratic_coef),
    .out_valid (out_valid),
    .applied   (applied),
    .force_all (force_all)
  );

  assign force_x = force_all[0*FORCE_W +: FORCE_W];
  assign force_y = force_all[1*FORCE_W +: FORCE_W];
  assign force_z = force_all[2*FORCE_W +: FORCE_W];

endmodule

@@ design/bwdf_front.sv @@
// Front stages: box test, relative velocity, squares and their sum.
// Depends on bwdf_pkg.
module bwdf_front #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bwdf_pkg::flow_t   flow_in,
  input  logic [3*CW-1:0]   pos,
  input  logic [3*CW-1:0]   vel,
  input  logic              infinite_mass,
  input  logic [3*CW-1:0]   wind,
  input  logic [3*CW-1:0]   center,
  input  logic [3*CW-1:0]   half,
  output bwdf_pkg::flow_t   flow_out,
  output logic [2*CW-1:0]   sum,
  output logic [3*CW+3:0]   side
);
  import bwdf_pkg::*;

  localparam logic signed [CW:0] VMAX = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0] VMIN = {2'b11, {(CW-1){1'b0}}};

  logic signed [CW+1:0] p_e   [3];
  logic signed [CW+1:0] c_e   [3];
  logic signed [CW+1:0] h_e   [3];
  logic signed [CW+1:0] hi_b  [3];
  logic signed [CW+1:0] lo_b  [3];
  logic signed [CW:0]   d     [3];
  logic signed [CW:0]   dsat  [3];
  logic signed [CW:0]   mag   [3];
  logic [2:0]           outside;
  logic [2:0]           neg_c;
  logic [3*CW-1:0]      av_c;
  logic [3*CW+3:0]      side_c;
  logic [2*CW-1:0]      av_w  [3];

  logic                 s1_valid;
  logic [3*CW+3:0]      s1_side;
  logic                 s2_valid;
  logic [3*CW+3:0]      s2_side;
  logic [2*CW-1:0]      s2_sq [3];
  logic                 s3_valid;
  logic [3*CW+3:0]      s3_side;
  logic [2*CW-1:0]      s3_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_e[i]  = {{2{pos[i*CW+CW-1]}}, pos[i*CW +: CW]};
      c_e[i]  = {{2{center[i*CW+CW-1]}}, center[i*CW +: CW]};
      h_e[i]  = {{2{half[i*CW+CW-1]}}, half[i*CW +: CW]};
      hi_b[i] = c_e[i] + h_e[i];
      lo_b[i] = c_e[i] - h_e[i];
      outside[i] = (p_e[i] > hi_b[i]) || (p_e[i] < lo_b[i]);
      d[i] = $signed({vel[i*CW+CW-1], vel[i*CW +: CW]})
           - $signed({wind[i*CW+CW-1], wind[i*CW +: CW]});
      if (d[i] > VMAX) begin
        dsat[i] = VMAX;
      end else if (d[i] < VMIN) begin
        dsat[i] = VMIN;
      end else begin
        dsat[i] = d[i];
      end
      neg_c[i] = dsat[i][CW];
      mag[i]   = neg_c[i] ? -dsat[i] : dsat[i];
      av_c[i*CW +: CW] = mag[i][CW-1:0];
    end
    side_c = {~infinite_mass & ~(|outside), neg_c, av_c};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av_w[i] = {{CW{1'b0}}, s1_side[i*CW +: CW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (flow_in.advance) begin
      s1_valid <= flow_in.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (flow_in.advance) begin
      s1_side <= side_c;
      s2_side <= s1_side;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= av_w[i] * av_w[i];
      end
      s3_side <= s2_side;
      s3_sum  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    end
  end

  assign flow_out.advance = flow_in.advance;
  assign flow_out.valid   = s3_valid;
  assign sum              = s3_sum;
  assign side             = s3_side;

endmodule

@@ design/bwdf_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on bwdf_pkg.
module bwdf_sqrt #(
  parameter int RW     = 16,
  parameter int SIDE_W = 52
) (
  input  logic              clk,
  input  logic              rst,
  input  bwdf_pkg::flow_t   flow_in,
  input  logic [2*RW-1:0]   n,
  input  logic [SIDE_W-1:0] side_in,
  output bwdf_pkg::flow_t   flow_out,
  output logic [RW-1:0]     root,
  output logic [SIDE_W-1:0] side_out
);
  import bwdf_pkg::*;

  logic              valid_q [RW];
  logic [RW+1:0]     rem_q   [RW];
  logic [RW-1:0]     root_q  [RW];
  logic [2*RW-1:0]   rest_q  [RW];
  logic [SIDE_W-1:0] side_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic              valid_i;
    logic [RW+1:0]     rem_i;
    logic [RW-1:0]     root_i;
    logic [2*RW-1:0]   rest_i;
    logic [SIDE_W-1:0] side_i;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign valid_i = flow_in.valid;
      assign rem_i   = '0;
      assign root_i  = '0;
      assign rest_i  = n;
      assign side_i  = side_in;
    end else begin : g_next
      assign valid_i = valid_q[k-1];
      assign rem_i   = rem_q[k-1];
      assign root_i  = root_q[k-1];
      assign rest_i  = rest_q[k-1];
      assign side_i  = side_q[k-1];
    end

    // bring down the next two bits and try the next root bit
    assign rem_sh = {rem_i[RW-1:0], rest_i[2*RW-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (flow_in.advance) begin
        valid_q[k] <= valid_i;
      end
    end

    always_ff @(posedge clk) begin
      if (flow_in.advance) begin
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_i[RW-2:0], take};
        rest_q[k] <= rest_i << 2;
        side_q[k] <= side_i;
      end
    end
  end

  assign flow_out.advance = flow_in.advance;
  assign flow_out.valid   = valid_q[RW-1];
  assign root             = root_q[RW-1];
  assign side_out         = side_q[RW-1];

endmodule

@@ design/bwdf_drag.sv @@
// Back stages: drag coefficient, split multiply, shift and saturation.
// Depends on bwdf_pkg.
module bwdf_drag #(
  parameter int CW = 16,
  parameter int FB = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bwdf_pkg::flow_t                 flow_in,
  input  logic [CW-1:0]                   root,
  input  logic [3*CW+3:0]                 side_in,
  input  logic [bwdf_pkg::COEF_W-1:0]     lin_coef,
  input  logic [bwdf_pkg::COEF_W-1:0]     quad_coef,
  output logic                            out_valid,
  output logic                            applied,
  output logic [3*bwdf_pkg::FORCE_W-1:0]  force_all
);
  import bwdf_pkg::*;

  localparam int QP_W = COEF_W + CW;
  localparam int LS_W = COEF_W + FB;
  localparam int CF_W = ((QP_W > LS_W) ? QP_W : LS_W) + 1;
  localparam int CL_W = (CF_W + 1) / 2;
  localparam int CH_W = CF_W - CL_W;
  localparam int PR_W = CW + CF_W;
  localparam logic [PR_W-1:0]    LIM    = PR_W'(1) << (FORCE_W - 1);
  localparam logic [FORCE_W-1:0] POSMAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEGMAX = {1'b1, {(FORCE_W-1){1'b0}}};

  logic              d1_valid;
  logic [3*CW+3:0]   d1_side;
  logic [QP_W-1:0]   d1_qp;
  logic              d2_valid;
  logic [3*CW+3:0]   d2_side;
  logic [CF_W-1:0]   d2_coef;
  logic              d3_valid;
  logic [3*CW+3:0]   d3_side;
  logic [CW+CL_W-1:0] d3_pl [3];
  logic [CW+CH_W-1:0] d3_ph [3];
  logic              d4_valid;
  logic              d4_applied;
  logic [3*FORCE_W-1:0] d4_force;

  logic [CW+CL_W-1:0] av_l  [3];
  logic [CW+CH_W-1:0] av_h  [3];
  logic [CW+CL_W-1:0] cl_w;
  logic [CW+CH_W-1:0] ch_w;
  logic [PR_W-1:0]    prod  [3];
  logic [PR_W-1:0]    p     [3];
  logic               ge    [3];
  logic [3*FORCE_W-1:0] force_c;

  always_comb begin
    cl_w = (CW+CL_W)'(d2_coef[CL_W-1:0]);
    ch_w = (CW+CH_W)'(d2_coef[CF_W-1:CL_W]);
    for (int i = 0; i < 3; i++) begin
      av_l[i] = (CW+CL_W)'(d2_side[i*CW +: CW]);
      av_h[i] = (CW+CH_W)'(d2_side[i*CW +: CW]);
    end
  end

  // recombine the partial products, truncate, then clamp per sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (PR_W'(d3_ph[i]) << CL_W) + PR_W'(d3_pl[i]);
      p[i]    = prod[i] >> FB;
      ge[i]   = (p[i] >= LIM);
      if (!d3_side[3*CW+3]) begin
        force_c[i*FORCE_W +: FORCE_W] = '0;
      end else if (d3_side[3*CW+i]) begin
        force_c[i*FORCE_W +: FORCE_W] = ge[i] ? POSMAX : p[i][FORCE_W-1:0];
      end else begin
        force_c[i*FORCE_W +: FORCE_W] = ge[i] ? NEGMAX : -p[i][FORCE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
      d4_valid <= 1'b0;
    end else if (flow_in.advance) begin
      d1_valid <= flow_in.valid;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
      d4_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (flow_in.advance) begin
      d1_side    <= side_in;
      d1_qp      <= QP_W'(quad_coef) * QP_W'(root);
      d2_side    <= d1_side;
      d2_coef    <= CF_W'(d1_qp) + (CF_W'(lin_coef) << FB);
      d3_side    <= d2_side;
      for (int i = 0; i < 3; i++) begin
        d3_pl[i] <= av_l[i] * cl_w;
        d3_ph[i] <= av_h[i] * ch_w;
      end
      d4_applied <= d3_side[3*CW+3];
      d4_force   <= force_c;
    end
  end

  assign out_valid = d4_valid;
  assign applied   = d4_applied;
  assign force_all = d4_force;

endmodule

@@ design/bwdf_checker.sv @@
// Port checker for box_wind_drag_force and the bind that attaches it.
// Depends on bwdf_pkg and box_wind_drag_force_assert.svh.
`include "box_wind_drag_force_assert.svh"

module bwdf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               applied,
  input logic [bwdf_pkg::FORCE_W-1:0]       force_x,
  input logic [bwdf_pkg::FORCE_W-1:0]       force_y,
  input logic [bwdf_pkg::FORCE_W-1:0]       force_z
);
  import bwdf_pkg::*;

  // hold a stalled result
  `BWDF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(applied) && $stable(force_x) && $stable(force_y) && $stable(force_z))

  // a skipped body carries no force
  `BWDF_ASSERT_IMP(a_skip_zero, out_valid && !applied, force_x == '0 && force_y == '0 && force_z == '0)

  // an empty output register never blocks the input
  `BWDF_ASSERT_IMP(a_ready_empty, !out_valid, in_ready)

  // reset drops every item in flight
  `BWDF_ASSERT_ALW(a_reset_flush, rst, !out_valid)

endmodule

bind box_wind_drag_force bwdf_checker u_bwdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .applied   (applied),
  .force_x   (force_x),
  .force_y   (force_y),
  .force_z   (force_z)
);

@@ tb/testbench.sv @@
// Self-checking testbench for box_wind_drag_force: a directed stimulus table,
// then random bodies over several register settings, each result checked against
// a typed or predicted force. Depends on bwdf_pkg and the box_wind_drag_force RTL.
module testbench;
  import bwdf_pkg::*;

  localparam int AXIS_W = 16;
  localparam int FRAC_BITS = 8;
  localparam int WORD_W = 3 * AXIS_W;
  // Register indexes that the block does not implement
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST = 3'd7;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 161;
  localparam int DRAIN_CYCLES = 2 * (AXIS_W + 7) + 10;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PRINT_CAP = 40;

  // One body as the block receives it; index 0 is x
  typedef struct packed {
    logic [2:0][AXIS_W-1:0] pos;
    logic [2:0][AXIS_W-1:0] vel;
    logic inf;
  } body_t;

  // One force result; index 0 is x
  typedef struct packed {
    logic app;
    logic [2:0][FORCE_W-1:0] f;
  } result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_KNOWN} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
    body_t b;
    result_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [AXIS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [AXIS_W-1:0] vel_x, vel_y, vel_z;
  logic infinite_mass;
  logic out_valid;
  logic out_ready;
  logic applied;
  logic signed [FORCE_W-1:0] force_x, force_y, force_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  // Predictor copy of the registers
  logic [WORD_W-1:0] wind_reg, center_reg, half_reg;
  logic [COEF_W-1:0] lin_coef, quad_coef;

  result_t force_due[$];
  plan_row_t plan[$];
  int errors;
  int results_seen;
  int sink_hold;
  bit calm;

  box_wind_drag_force #(
    .COORD_WIDTH(AXIS_W),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .vel_z(vel_z),
    .infinite_mass(infinite_mass),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .applied(applied),
    .force_x(force_x),
    .force_y(force_y),
    .force_z(force_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor of the square root, one result bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int bitpos = 20; bitpos >= 0; bitpos--) begin
      trial = root | (longint'(1) << bitpos);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Drag on one axis: -(|v|*coef >> FRAC_BITS) with the sign of -v, then clamp
  function automatic logic [FORCE_W-1:0] drag_axis(int v, longint unsigned coef);
    longint unsigned mag;
    longint unsigned prod;
    if (v == 0) return '0;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    prod = (mag * coef) >> FRAC_BITS;
    if (v > 0) begin
      if (prod >= 64'h8000_0000) return 32'h8000_0000;
      return -prod[FORCE_W-1:0];
    end
    if (prod > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return prod[FORCE_W-1:0];
  endfunction

  function automatic result_t predict_force(body_t b);
    result_t r;
    int p, cc, hh, d;
    int v[3];
    longint unsigned sumsq;
    longint unsigned coef;
    r = '0;
    // Skip bodies of infinite mass and bodies outside the box
    if (b.inf) return r;
    for (int i = 0; i < 3; i++) begin
      p = $signed(b.pos[i]);
      cc = $signed(center_reg[AXIS_W*i +: AXIS_W]);
      hh = $signed(half_reg[AXIS_W*i +: AXIS_W]);
      if (p > cc + hh || p < cc - hh) return r;
    end
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      d = $signed(b.vel[i]);
      d = d - $signed(wind_reg[AXIS_W*i +: AXIS_W]);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      v[i] = d;
      sumsq += longint'(d) * longint'(d);
    end
    coef = (longint'(lin_coef) << FRAC_BITS) + longint'(quad_coef) * floor_root(sumsq);
    r.app = 1'b1;
    for (int i = 0; i < 3; i++) r.f[i] = drag_axis(v[i], coef);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_error(string msg);
    if (errors < PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Compare every accepted result with the oldest expected force
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (force_due.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        w = force_due.pop_front();
        if (applied !== w.app)
          note_error($sformatf("result %0d applied %b, want %b", results_seen, applied, w.app));
        if (force_x !== w.f[0])
          note_error($sformatf("result %0d force_x %h, want %h", results_seen, force_x, w.f[0]));
        if (force_y !== w.f[1])
          note_error($sformatf("result %0d force_y %h, want %h", results_seen, force_y, w.f[1]));
        if (force_z !== w.f[2])
          note_error($sformatf("result %0d force_z %h, want %h", results_seen, force_z, w.f[2]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one; none while calm
  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Result side: hold ready high, then drop it for a random stretch
  always @(negedge clk) begin
    if (sink_hold != 0) begin
      out_ready = 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ready = 1'b1;
      if (!calm && $urandom_range(0, 2) == 0) sink_hold = pause_len();
    end
  end

  // Send one body after a random gap; record what it must produce
  task automatic send_body(body_t b, bit known, result_t want);
    int gap;
    @(negedge clk);
    gap = pause_len();
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    pos_x = b.pos[0];
    pos_y = b.pos[1];
    pos_z = b.pos[2];
    vel_x = b.vel[0];
    vel_y = b.vel[1];
    vel_z = b.vel[2];
    infinite_mass = b.inf;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    force_due.push_back(known ? want : predict_force(b));
  endtask

  // Drop valid and wait until every expected result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (force_due.size() != 0) @(posedge clk);
  endtask

  // Write one register; the predictor copy follows on acceptance
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_WIND: wind_reg = data;
      REG_CENTER: center_reg = data;
      REG_HALF: half_reg = data;
      REG_LIN: lin_coef = data[COEF_W-1:0];
      REG_QUAD: quad_coef = data[COEF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic body_t body_of(logic [AXIS_W-1:0] px, logic [AXIS_W-1:0] py,
                                    logic [AXIS_W-1:0] pz, logic [AXIS_W-1:0] vx,
                                    logic [AXIS_W-1:0] vy, logic [AXIS_W-1:0] vz,
                                    logic inf);
    body_t b;
    b.pos[0] = px;
    b.pos[1] = py;
    b.pos[2] = pz;
    b.vel[0] = vx;
    b.vel[1] = vy;
    b.vel[2] = vz;
    b.inf = inf;
    return b;
  endfunction

  function automatic result_t force_of(logic app, logic [FORCE_W-1:0] fx,
                                       logic [FORCE_W-1:0] fy, logic [FORCE_W-1:0] fz);
    result_t r;
    r.app = app;
    r.f[0] = fx;
    r.f[1] = fy;
    r.f[2] = fz;
    return r;
  endfunction

  task automatic put_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    plan.push_back('{ROW_WRITE, idx, data, '0, '0});
  endtask

  task automatic put_body(body_t b);
    plan.push_back('{ROW_PREDICT, '0, '0, b, '0});
  endtask

  task automatic put_known(body_t b, result_t want);
    plan.push_back('{ROW_KNOWN, '0, '0, b, want});
  endtask

  // Directed table: typed results where they are obvious, predictor elsewhere
  task automatic build_plan();
    result_t skipped;
    skipped = force_of(1'b0, 0, 0, 0);
    // After reset: box collapses to the origin and both coefficients are zero
    put_known(body_of(0, 0, 0, 16'h7FFF, 16'h8000, 16'h1234, 0), force_of(1'b1, 0, 0, 0));
    put_known(body_of(0, 0, 0, 16'h7FFF, 16'h8000, 16'h1234, 1), skipped);
    put_known(body_of(16'h0001, 0, 0, 16'h0100, 0, 0, 0), skipped);
    put_known(body_of(0, 0, 16'hFFFF, 0, 0, 16'h0100, 0), skipped);
    // Widest box, largest coefficients; upper data bits of coefficient writes ignored
    put_write(REG_HALF, 48'h7FFF_7FFF_7FFF);
    put_write(REG_LIN, 48'hABCD_1234_FFFF);
    put_write(REG_QUAD, 48'h5555_AAAA_FFFF);
    put_known(body_of(16'h8001, 16'h7FFF, 0, 16'h8000, 16'h7FFF, 0, 0),
              force_of(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    put_known(body_of(16'h8000, 0, 0, 16'h0100, 0, 0, 0), skipped);
    put_known(body_of(0, 16'h7FFF, 0, 16'h0100, 0, 0, 1), skipped);
    // Wind at the extremes: relative velocity saturates on x and y
    put_write(REG_WIND, 48'h0100_8000_7FFF);
    put_body(body_of(0, 0, 0, 16'h8000, 16'h7FFF, 16'h0100, 0));
    put_known(body_of(0, 0, 0, 16'h7FFF, 16'h8000, 16'h0100, 0), force_of(1'b1, 0, 0, 0));
    // Linear drag of one: unit velocity gives unit force against it
    put_write(REG_WIND, '0);
    put_write(REG_LIN, 48'h0000_0000_0100);
    put_write(REG_QUAD, '0);
    put_known(body_of(0, 0, 0, 16'h0100, 16'hFF00, 0, 0),
              force_of(1'b1, 32'hFFFF_0000, 32'h0001_0000, 0));
    put_body(body_of(16'h1234, 16'hEDCB, 16'h0042, 16'h0037, 16'hFFC1, 16'h0200, 0));
    // Pure quadratic drag on a 3-4-5 velocity
    put_write(REG_LIN, '0);
    put_write(REG_QUAD, 48'h0000_0000_0100);
    put_body(body_of(0, 0, 0, 16'h0300, 16'h0400, 0, 0));
    // Negative half width on x: nothing is inside
    put_write(REG_CENTER, 48'h0100_FF00_0200);
    put_write(REG_HALF, 48'h0010_0000_8000);
    put_known(body_of(16'h0200, 16'hFF00, 16'h0100, 16'h0100, 0, 0, 0), skipped);
    // Small off-center box: bounds are inside, one step past is not
    put_write(REG_HALF, 48'h0010_0000_0020);
    put_body(body_of(16'h0220, 16'hFF00, 16'h00F0, 16'h0100, 16'h0100, 16'h0100, 0));
    put_body(body_of(16'h01E0, 16'hFF00, 16'h0110, 16'hFF00, 16'h0080, 16'h8000, 0));
    put_known(body_of(16'h0221, 16'hFF00, 16'h0100, 16'h0100, 0, 0, 0), skipped);
    put_known(body_of(16'h0200, 16'hFF01, 16'h0100, 16'h0100, 0, 0, 0), skipped);
    // z bound comes from the z center, not the y center
    put_known(body_of(16'h0200, 16'hFF00, 16'h0111, 16'h0100, 0, 0, 0), skipped);
    put_known(body_of(16'h0200, 16'hFF00, 16'h00EF, 16'h0100, 0, 0, 0), skipped);
    // Write to an unimplemented index: nothing changes
    put_write(REG_UNUSED_FIRST, '1);
    put_body(body_of(16'h0220, 16'hFF00, 16'h00F0, 16'h0100, 16'h0100, 16'h0100, 0));
  endtask

  function automatic logic [AXIS_W-1:0] any_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3, 4, 5, 6: return AXIS_W'($urandom_range(0, 16'h1000)) - 16'h0800;
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] any_half();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return AXIS_W'($urandom) | 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      default: return AXIS_W'($urandom_range(0, 16'h0C00));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] any_coef();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return '0;
      1: return '1;
      2: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 16'h03FF));
    endcase
  endfunction

  // Position on one axis: inside the box, on a bound, or one step past it
  function automatic logic [AXIS_W-1:0] coord_near_box(int axis, int mode);
    int c, h, lo, hi, x;
    c = $signed(center_reg[AXIS_W*axis +: AXIS_W]);
    h = $signed(half_reg[AXIS_W*axis +: AXIS_W]);
    lo = c - h;
    hi = c + h;
    case (mode)
      0: begin
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        if (lo <= hi) x = lo + int'($urandom_range(hi - lo, 0));
        else x = $signed(AXIS_W'($urandom));
      end
      1: x = lo;
      2: x = hi;
      3: x = lo - 1;
      default: x = hi + 1;
    endcase
    if (x < -32768 || x > 32767) x = $signed(AXIS_W'($urandom));
    return x[AXIS_W-1:0];
  endfunction

  // Mostly bodies inside the box, some on its edges, the rest noise
  function automatic body_t random_body();
    body_t b;
    int r;
    int edge_axis;
    r = $urandom_range(0, 99);
    edge_axis = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      if (r < 70) b.pos[i] = coord_near_box(i, 0);
      else if (r < 85) b.pos[i] = coord_near_box(i, (i == edge_axis) ?
                                                 $urandom_range(1, 4) : 0);
      else b.pos[i] = AXIS_W'($urandom);
      if ($urandom_range(0, 9) < 3) b.vel[i] = AXIS_W'($urandom);
      else b.vel[i] = wind_reg[AXIS_W*i +: AXIS_W] + AXIS_W'($urandom_range(0, 16'h0C00))
                      - 16'h0600;
    end
    b.inf = (r >= 85) ? 1'($urandom) : 1'b0;
    return b;
  endfunction

  // New register setting per phase; the first three phases pin the extremes
  task automatic load_phase_config(int ph);
    logic [WORD_W-1:0] w, c, h;
    logic [COEF_W-1:0] k1, k2;
    logic [CFG_IDX_W-1:0] spare;
    for (int i = 0; i < 3; i++) begin
      w[AXIS_W*i +: AXIS_W] = any_coord();
      c[AXIS_W*i +: AXIS_W] = any_coord();
      h[AXIS_W*i +: AXIS_W] = any_half();
    end
    k1 = any_coef();
    k2 = any_coef();
    if (ph == 0) begin
      h = {3{16'h7FFF}};
      k1 = '1;
      k2 = '1;
    end else if (ph == 1) begin
      h = '0;
      k1 = '0;
      k2 = '0;
    end else if (ph == 2) begin
      w = {3{16'h8000}};
      c = {3{16'h8000}};
      h = {3{16'h7FFF}};
    end
    spare = $urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST);
    wait_drained();
    write_reg(spare, {AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom)});
    write_reg(REG_QUAD, {AXIS_W'($urandom), AXIS_W'($urandom), k2});
    write_reg(REG_WIND, w);
    write_reg(REG_HALF, h);
    write_reg(REG_LIN, {AXIS_W'($urandom), AXIS_W'($urandom), k1});
    write_reg(REG_CENTER, c);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    vel_x = '0;
    vel_y = '0;
    vel_z = '0;
    infinite_mass = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wind_reg = '0;
    center_reg = '0;
    half_reg = '0;
    lin_coef = '0;
    quad_coef = '0;
    errors = 0;
    results_seen = 0;
    sink_hold = 0;
    calm = 1'b0;
    build_plan();

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          wait_drained();
          write_reg(plan[i].idx, plan[i].data);
        end
        ROW_PREDICT: send_body(plan[i].b, 1'b0, '0);
        default: send_body(plan[i].b, 1'b1, plan[i].want);
      endcase
    end

    // Random bodies, one register setting per phase; calm stretches now and then
    for (int ph = 0; ph < PHASES; ph++) begin
      load_phase_config(ph);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 4) == 0);
        send_body(random_body(), 1'b0, '0);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Some tests failed");
    $finish;
  end

endmodule
